### rtl/cdq_pkg.sv
package cdq_pkg;

  localparam int unsigned DefaultDepth     = 8;
  localparam int unsigned DefaultDataWidth = 32;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_REAR  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

### rtl/cdq_mem.sv
module cdq_mem #(
  parameter int unsigned DEPTH      = cdq_pkg::DefaultDepth,
  parameter int unsigned DATA_WIDTH = cdq_pkg::DefaultDataWidth,
  localparam int unsigned AW        = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  cdq_pkg::mem_ctl_t     ctl_i,
  input  logic [AW-1:0]         addr_i,
  input  logic [DATA_WIDTH-1:0] wdata_i,
  output logic [DATA_WIDTH-1:0] rdata_o
);

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (ctl_i.re) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/cdq_ctrl.sv
module cdq_ctrl #(
  parameter int unsigned DEPTH      = cdq_pkg::DefaultDepth,
  localparam int unsigned AW        = $clog2(DEPTH),
  localparam int unsigned CW        = $clog2(DEPTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [2:0]            operation_i,
  output logic                  busy_o,
  output cdq_pkg::mem_ctl_t     mem_ctl_o,
  output logic [AW-1:0]         mem_addr_o,
  output logic                  done_o,
  output logic                  rd_sel_o,
  output logic [1:0]            status_o,
  output logic [CW-1:0]         occupancy_o
);

  localparam logic [AW-1:0] LastSlot = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt  = CW'(DEPTH);

  logic              pending_q;
  logic [AW-1:0]     head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]     count_q, count_d;
  logic              rd_sel_q, rd_sel_d;
  cdq_pkg::status_e  status_q, status_d;
  logic              accept;
  logic              full, empty;
  logic [AW-1:0]     head_dn, tail_up, head_up, tail_dn;

  assign accept = start_i && !pending_q;
  assign full   = (count_q == FullCnt);
  assign empty  = (count_q == '0);

  assign head_dn = (head_q == '0) ? LastSlot : head_q - 1'b1;
  assign head_up = (head_q == LastSlot) ? '0 : head_q + 1'b1;
  assign tail_up = (tail_q == LastSlot) ? '0 : tail_q + 1'b1;
  assign tail_dn = (tail_q == '0) ? LastSlot : tail_q - 1'b1;

  always_comb begin
    head_d        = head_q;
    tail_d        = tail_q;
    count_d       = count_q;
    rd_sel_d      = 1'b0;
    status_d      = cdq_pkg::ST_OK;
    mem_ctl_o     = '0;
    mem_addr_o    = head_q;
    case (cdq_pkg::op_e'(operation_i))
      cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_PUSH_REAR: begin
        if (full) begin
          status_d = cdq_pkg::ST_FULL;
        end else begin
          mem_ctl_o.we = accept;
          count_d      = count_q + 1'b1;
          if (empty) begin
            head_d     = '0;
            tail_d     = '0;
            mem_addr_o = '0;
          end else if (cdq_pkg::op_e'(operation_i) == cdq_pkg::OP_PUSH_FRONT) begin
            head_d     = head_dn;
            mem_addr_o = head_dn;
          end else begin
            tail_d     = tail_up;
            mem_addr_o = tail_up;
          end
        end
      end
      cdq_pkg::OP_POP_FRONT, cdq_pkg::OP_PEEK_FRONT,
      cdq_pkg::OP_POP_REAR, cdq_pkg::OP_PEEK_REAR: begin
        if (empty) begin
          status_d = cdq_pkg::ST_EMPTY;
        end else begin
          mem_ctl_o.re = accept;
          rd_sel_d     = 1'b1;
          if (cdq_pkg::op_e'(operation_i) == cdq_pkg::OP_POP_FRONT ||
              cdq_pkg::op_e'(operation_i) == cdq_pkg::OP_PEEK_FRONT) begin
            mem_addr_o = head_q;
          end else begin
            mem_addr_o = tail_q;
          end
          if (cdq_pkg::op_e'(operation_i) == cdq_pkg::OP_POP_FRONT) begin
            head_d  = head_up;
            count_d = count_q - 1'b1;
          end else if (cdq_pkg::op_e'(operation_i) == cdq_pkg::OP_POP_REAR) begin
            tail_d  = tail_dn;
            count_d = count_q - 1'b1;
          end
          // last element gone: rewind both ends
          if (count_d == '0) begin
            head_d = '0;
            tail_d = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= '0;
      rd_sel_q  <= 1'b0;
      status_q  <= cdq_pkg::ST_OK;
    end else begin
      pending_q <= accept;
      if (accept) begin
        head_q   <= head_d;
        tail_q   <= tail_d;
        count_q  <= count_d;
        rd_sel_q <= rd_sel_d;
        status_q <= status_d;
      end
    end
  end

  assign busy_o      = pending_q;
  assign done_o      = pending_q;
  assign rd_sel_o    = rd_sel_q;
  assign status_o    = status_q;
  assign occupancy_o = count_q;

endmodule

### rtl/circular_deque.sv
// Channel  | Handshake          | Word
// ---------+--------------------+--------------------------------------
// request  | start_i / busy_o   | operation_i, push_value_i
// result   | done_o (1 cycle)   | read_value_o, status_o, occupancy_o
//
// An operation accepted at one edge has its result on the ports in the
// next cycle, marked by done_o; busy_o is high for that cycle, so no new
// operation is taken while a result is out. The slot memory read is registered.
// Reset clears pointers and occupancy; slots are not cleared.
// The result side cannot stall.
module circular_deque #(
  parameter int unsigned DEPTH      = cdq_pkg::DefaultDepth,
  parameter int unsigned DATA_WIDTH = cdq_pkg::DefaultDataWidth,
  localparam int unsigned AW        = $clog2(DEPTH),
  localparam int unsigned CW        = $clog2(DEPTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [2:0]            operation_i,
  input  logic [DATA_WIDTH-1:0] push_value_i,
  output logic                  done_o,
  output logic [DATA_WIDTH-1:0] read_value_o,
  output logic [1:0]            status_o,
  output logic [CW-1:0]         occupancy_o
);

  cdq_pkg::mem_ctl_t     mem_ctl;
  logic [AW-1:0]         mem_addr;
  logic [DATA_WIDTH-1:0] mem_rdata;
  logic                  rd_sel;

  cdq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .operation_i (operation_i),
    .busy_o      (busy_o),
    .mem_ctl_o   (mem_ctl),
    .mem_addr_o  (mem_addr),
    .done_o      (done_o),
    .rd_sel_o    (rd_sel),
    .status_o    (status_o),
    .occupancy_o (occupancy_o)
  );

  cdq_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .addr_i  (mem_addr),
    .wdata_i (push_value_i),
    .rdata_o (mem_rdata)
  );

  assign read_value_o = rd_sel ? mem_rdata : '0;

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> done_o)
    else $error("accepted operation gave no result");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held longer than one cycle");

  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != cdq_pkg::ST_OK) |-> (read_value_o == '0))
    else $error("refused operation returned data");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (occupancy_o <= CW'(DEPTH)))
    else $error("occupancy beyond depth");

  a_no_access_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !(mem_ctl.we || mem_ctl.re))
    else $error("memory accessed while an operation is in flight");

endmodule
